/* src/i2cbc_pkg.sv */
// Shared types and constants for the I2C bus-clear sequencer.
// Used by i2cbc_cfg_regs and i2c_bus_clear_recovery; depends on nothing.
package i2cbc_pkg;

    localparam int HALF_W   = 16;
    localparam int POLL_W   = 20;
    localparam int PULSE_W  = 8;
    localparam int SPOLL_W  = 8;
    localparam int TIMER_W  = 20;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W  = 3;
    localparam int STATUS_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_POLL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POLLS    = 2'd3;

    // reset values
    localparam logic [HALF_W-1:0]  RST_HALF_PERIOD  = 16'd10;
    localparam logic [POLL_W-1:0]  RST_STRETCH_POLL = 20'd100000;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSES   = 8'd20;
    localparam logic [SPOLL_W-1:0] RST_MAX_POLLS    = 8'd20;

    // sequence phases
    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CHECK      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PULSE_LOW  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PULSE_HIGH = 3'd3;
    localparam logic [PHASE_W-1:0] PH_STRETCH    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_STOP_LOW   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_STOP_HIGH  = 3'd6;

    // completion codes
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SCL_LOW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STRETCH   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SDA_STUCK = 2'd3;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0]  half_period_ticks;
        logic [POLL_W-1:0]  stretch_poll_ticks;
        logic [PULSE_W-1:0] max_pulses;
        logic [SPOLL_W-1:0] max_stretch_polls;
    } t_cfg;

endpackage

/* src/i2cbc_cfg_regs.sv */
// Configuration register bank of the I2C bus-clear sequencer.
// Depends on i2cbc_pkg; presents the registers as one t_cfg struct.
module i2cbc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [i2cbc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [i2cbc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output i2cbc_pkg::t_cfg                 o_cfg
);
    import i2cbc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks  <= RST_HALF_PERIOD;
            r_cfg.stretch_poll_ticks <= RST_STRETCH_POLL;
            r_cfg.max_pulses         <= RST_MAX_PULSES;
            r_cfg.max_stretch_polls  <= RST_MAX_POLLS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_HALF_PERIOD:  r_cfg.half_period_ticks  <= i_cfg_wdata[HALF_W-1:0];
                REG_STRETCH_POLL: r_cfg.stretch_poll_ticks <= i_cfg_wdata[POLL_W-1:0];
                REG_MAX_PULSES:   r_cfg.max_pulses         <= i_cfg_wdata[PULSE_W-1:0];
                REG_MAX_POLLS:    r_cfg.max_stretch_polls  <= i_cfg_wdata[SPOLL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/i2c_bus_clear_recovery.sv */
// Top level of the I2C bus-clear sequencer: phase machine and result register.
// Depends on i2cbc_pkg and i2cbc_cfg_regs.
//
//  channel   direction  tdata (low bit up)                             tuser / tlast
//  s_axis    in         sda_level, scl_level, 6'b0                     tuser: kind
//  m_axis    out        scl_drive_low, sda_drive_low, busy_res,        tlast: done_res
//                       status[1:0], 3'b0
//  cfg       in         write port, index 0..3, 20-bit data            -
//
// One transaction in gives one transaction out, in the cycle after it is taken; a
// transaction is taken every cycle while the output is not stalled. The phase machine
// updates on the accepting edge and its result is held in a single output register,
// so input is taken whenever that register is empty or being emptied. Reset is
// synchronous and clears the phase, timer, counters, status and output valid.
module i2c_bus_clear_recovery (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // sda_level, scl_level
    input  logic                            s_axis_tuser,  // kind
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // scl_drive_low, sda_drive_low, busy_res, status[1:0]
    output logic [7:0]                      m_axis_tdata,
    output logic                            m_axis_tlast,  // done_res
    input  logic                            i_cfg_wr_en,
    input  logic [i2cbc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [i2cbc_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import i2cbc_pkg::*;

    t_cfg cfg;

    i2cbc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    logic [PHASE_W-1:0]  r_phase,  n_phase;
    logic [TIMER_W-1:0]  r_timer,  n_timer;
    logic [PULSE_W-1:0]  r_pulses, n_pulses;
    logic [SPOLL_W-1:0]  r_polls,  n_polls;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                n_done;
    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic                r_out_last;

    logic                kind, sda, scl, expired, accept;
    logic [TIMER_W-1:0]  half_load, poll_load;
    logic [PULSE_W-1:0]  pulses_seen;
    logic [SPOLL_W-1:0]  polls_dec;

    assign kind      = s_axis_tuser;
    assign sda       = s_axis_tdata[0];
    assign scl       = s_axis_tdata[1];
    assign expired   = (r_timer <= TIMER_W'(1));
    assign half_load = TIMER_W'(cfg.half_period_ticks);
    assign poll_load = cfg.stretch_poll_ticks;
    assign polls_dec = r_polls - SPOLL_W'(1);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_pulses    = r_pulses;
        n_polls     = r_polls;
        n_status    = r_status;
        n_done      = 1'b0;
        pulses_seen = r_pulses;

        if (kind == KIND_START) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_CHECK;
                n_timer = '0;
            end
        end else begin
            unique case (r_phase) inside
                PH_IDLE: ;
                PH_CHECK: begin
                    if (!scl) begin
                        n_phase  = PH_IDLE;
                        n_timer  = '0;
                        n_status = ST_SCL_LOW;
                        n_done   = 1'b1;
                    end else begin
                        // reload the pulse budget before the SDA decision
                        pulses_seen = cfg.max_pulses;
                        n_pulses    = cfg.max_pulses;
                        n_phase     = PH_PULSE_HIGH; // marker, resolved below
                    end
                end
                PH_PULSE_LOW, PH_STOP_LOW: begin
                    if (expired) begin
                        n_phase = (r_phase == PH_PULSE_LOW) ? PH_PULSE_HIGH : PH_STOP_HIGH;
                        n_timer = half_load;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                PH_PULSE_HIGH: begin
                    if (!expired) begin
                        n_timer = r_timer - TIMER_W'(1);
                    end else if (!scl) begin
                        if (cfg.max_stretch_polls == '0) begin
                            n_phase  = PH_IDLE;
                            n_timer  = '0;
                            n_status = ST_STRETCH;
                            n_done   = 1'b1;
                        end else begin
                            n_polls = cfg.max_stretch_polls;
                            n_phase = PH_STRETCH;
                            n_timer = poll_load;
                        end
                    end
                end
                PH_STRETCH: begin
                    if (!expired) begin
                        n_timer = r_timer - TIMER_W'(1);
                    end else begin
                        n_polls = polls_dec;
                        if (!scl) begin
                            if (polls_dec == '0) begin
                                n_phase  = PH_IDLE;
                                n_timer  = '0;
                                n_status = ST_STRETCH;
                                n_done   = 1'b1;
                            end else begin
                                n_timer = poll_load;
                            end
                        end
                    end
                end
                PH_STOP_HIGH: begin
                    if (expired) begin
                        n_phase  = PH_IDLE;
                        n_timer  = '0;
                        n_status = ST_CLEARED;
                        n_done   = 1'b1;
                    end else begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                end
                default: n_phase = PH_IDLE;
            endcase

            // SCL seen high at a check, a pulse end or a poll: decide on SDA
            if (((r_phase == PH_CHECK) && scl) ||
                (((r_phase == PH_PULSE_HIGH) || (r_phase == PH_STRETCH)) && expired && scl))
            begin
                if (sda) begin
                    n_phase = PH_STOP_LOW;
                    n_timer = half_load;
                end else if (pulses_seen != '0) begin
                    n_pulses = pulses_seen - PULSE_W'(1);
                    n_phase  = PH_PULSE_LOW;
                    n_timer  = half_load;
                end else begin
                    n_phase  = PH_IDLE;
                    n_timer  = '0;
                    n_status = ST_SDA_STUCK;
                    n_done   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_pulses    <= '0;
            r_polls     <= '0;
            r_status    <= ST_CLEARED;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_timer  <= n_timer;
                r_pulses <= n_pulses;
                r_polls  <= n_polls;
                r_status <= n_status;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register: hold while the result is stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {3'b000, n_status, (n_phase != PH_IDLE),
                           (n_phase == PH_STOP_LOW), (n_phase == PH_PULSE_LOW)};
            r_out_last <= n_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
